// ===== rtl/rhc_pkg.sv =====
package rhc_pkg;

    localparam int PixW = 8;
    localparam int HueW = 15;
    localparam int QuoW = 12;

    localparam logic [HueW-1:0] HUE_GREEN_BASE = 15'd7680;
    localparam logic [HueW-1:0] HUE_BLUE_BASE  = 15'd15360;
    localparam logic [HueW-1:0] HUE_TURN       = 15'd23040;

    typedef enum logic [1:0] {
        BR_RED,
        BR_GREEN,
        BR_BLUE
    } branch_t;

    // one pixel in flight: both divisions share the row of cells
    typedef struct packed {
        branch_t             branch;
        logic                neg;
        logic                gray;
        logic [PixW-1:0]     bright;
        logic [PixW-1:0]     delta;
        logic [PixW-1:0]     rem_hue;
        logic [PixW-1:0]     rem_sat;
        logic [QuoW-1:0]     num_hue;
        logic [QuoW-1:0]     num_sat;
        logic [QuoW-1:0]     q_hue;
        logic [QuoW-1:0]     q_sat;
    } work_t;

endpackage

// ===== rtl/rgb_to_hsv_convert_core.sv =====
// RGB to HSV pixel converter.
// Input channel: s_red, s_green, s_blue with s_valid / s_ready. One result
// item per input item on m_hue (1/64 degree, 0..23039), m_saturation
// (0..255) and m_brightness (largest channel), with m_valid / m_ready.
// The block holds no state between pixels.
// 14 register stages: one for max, min and numerators, a row of 12 divider
// cells (one quotient bit of both the hue and the saturation division per
// cell), one stage for the hue sector offset and output register.
// Throughput: one item per cycle while m_ready is high; all stages advance.
// When m_ready is low the row fills up from the output end, bubbles are
// squeezed out, and s_ready drops only once every stage holds an item.
// Results are never dropped or repeated while stalled.
// Reset (aresetn low at a rising edge of aclk) empties the pipeline; items
// in flight are discarded and the block accepts input on the next cycle.
module rgb_to_hsv_convert_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [14:0] m_hue,
    output logic [7:0]  m_saturation,
    output logic [7:0]  m_brightness
);

    rhc_pkg::work_t stage_data  [rhc_pkg::QuoW+1];
    logic           stage_valid [rhc_pkg::QuoW+1];
    logic           stage_ready [rhc_pkg::QuoW+1];

    rhc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_red    (s_red),
        .in_green  (s_green),
        .in_blue   (s_blue),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_data  (stage_data[0])
    );

    for (genvar i = 0; i < rhc_pkg::QuoW; i++) begin : g_cell
        rhc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[i]),
            .in_ready  (stage_ready[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_ready (stage_ready[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    rhc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (stage_valid[rhc_pkg::QuoW]),
        .in_ready       (stage_ready[rhc_pkg::QuoW]),
        .in_data        (stage_data[rhc_pkg::QuoW]),
        .out_valid      (m_valid),
        .out_ready      (m_ready),
        .out_hue        (m_hue),
        .out_saturation (m_saturation),
        .out_brightness (m_brightness)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_hue < rhc_pkg::HUE_TURN)
        else $error("hue out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturation == 8'd0 |-> m_hue == 15'd0)
        else $error("grey item with nonzero hue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturation != 8'd0 |-> m_brightness != 8'd0)
        else $error("saturation without brightness");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled while output not stalled");

endmodule

// ===== rtl/rhc_front.sv =====
module rhc_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [rhc_pkg::PixW-1:0]  in_red,
    input  logic [rhc_pkg::PixW-1:0]  in_green,
    input  logic [rhc_pkg::PixW-1:0]  in_blue,
    output logic                      out_valid,
    input  logic                      out_ready,
    output rhc_pkg::work_t            out_data
);

    logic                     valid_reg;
    rhc_pkg::work_t           data_reg;
    rhc_pkg::work_t           data_next;
    logic [rhc_pkg::PixW-1:0] mx;
    logic [rhc_pkg::PixW-1:0] mn;
    logic [rhc_pkg::PixW-1:0] dlt;
    logic [rhc_pkg::PixW-1:0] op_a;
    logic [rhc_pkg::PixW-1:0] op_b;
    logic [rhc_pkg::PixW-1:0] mag;
    logic [19:0]              num_hue;
    logic [19:0]              num_sat;
    rhc_pkg::branch_t         br;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        mx = in_red;
        if (in_green > mx) mx = in_green;
        if (in_blue > mx)  mx = in_blue;
        mn = in_red;
        if (in_green < mn) mn = in_green;
        if (in_blue < mn)  mn = in_blue;
        dlt = mx - mn;

        if (in_red == mx) begin
            br   = rhc_pkg::BR_RED;
            op_a = in_green;
            op_b = in_blue;
        end else if (in_green == mx) begin
            br   = rhc_pkg::BR_GREEN;
            op_a = in_blue;
            op_b = in_red;
        end else begin
            br   = rhc_pkg::BR_BLUE;
            op_a = in_red;
            op_b = in_green;
        end
        mag = (op_a >= op_b) ? (op_a - op_b) : (op_b - op_a);

        // 3840 * mag and 255 * delta by shift and subtract
        num_hue = {mag, 12'd0} - {4'd0, mag, 8'd0};
        num_sat = {4'd0, dlt, 8'd0} - {12'd0, dlt};

        data_next         = '0;
        data_next.branch  = br;
        data_next.neg     = op_a < op_b;
        data_next.gray    = dlt == '0;
        data_next.bright  = mx;
        data_next.delta   = dlt;
        data_next.rem_hue = num_hue[19:12];
        data_next.rem_sat = num_sat[19:12];
        data_next.num_hue = num_hue[11:0];
        data_next.num_sat = num_sat[11:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/rhc_cell.sv =====
module rhc_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  rhc_pkg::work_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output rhc_pkg::work_t  out_data
);

    logic                   valid_reg;
    rhc_pkg::work_t         data_reg;
    rhc_pkg::work_t         data_next;
    logic [rhc_pkg::PixW:0] trial_hue;
    logic [rhc_pkg::PixW:0] trial_sat;
    logic                   bit_hue;
    logic                   bit_sat;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // one restoring step of each division
    always_comb begin
        trial_hue = {in_data.rem_hue, in_data.num_hue[rhc_pkg::QuoW-1]};
        trial_sat = {in_data.rem_sat, in_data.num_sat[rhc_pkg::QuoW-1]};
        bit_hue   = trial_hue >= {1'b0, in_data.delta};
        bit_sat   = trial_sat >= {1'b0, in_data.bright};

        data_next         = in_data;
        data_next.rem_hue = bit_hue ? rhc_pkg::PixW'(trial_hue - {1'b0, in_data.delta})
                                    : trial_hue[rhc_pkg::PixW-1:0];
        data_next.rem_sat = bit_sat ? rhc_pkg::PixW'(trial_sat - {1'b0, in_data.bright})
                                    : trial_sat[rhc_pkg::PixW-1:0];
        data_next.num_hue = {in_data.num_hue[rhc_pkg::QuoW-2:0], 1'b0};
        data_next.num_sat = {in_data.num_sat[rhc_pkg::QuoW-2:0], 1'b0};
        data_next.q_hue   = {in_data.q_hue[rhc_pkg::QuoW-2:0], bit_hue};
        data_next.q_sat   = {in_data.q_sat[rhc_pkg::QuoW-2:0], bit_sat};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/rhc_back.sv =====
module rhc_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  rhc_pkg::work_t            in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [rhc_pkg::HueW-1:0]  out_hue,
    output logic [rhc_pkg::PixW-1:0]  out_saturation,
    output logic [rhc_pkg::PixW-1:0]  out_brightness
);

    logic                     valid_reg;
    logic [rhc_pkg::HueW-1:0] hue_reg;
    logic [rhc_pkg::PixW-1:0] sat_reg;
    logic [rhc_pkg::PixW-1:0] bright_reg;
    logic [rhc_pkg::HueW-1:0] hue_next;
    logic [rhc_pkg::HueW-1:0] qx;

    assign in_ready       = !valid_reg || out_ready;
    assign out_valid      = valid_reg;
    assign out_hue        = hue_reg;
    assign out_saturation = sat_reg;
    assign out_brightness = bright_reg;

    always_comb begin
        qx = rhc_pkg::HueW'(in_data.q_hue);
        case (in_data.branch)
            rhc_pkg::BR_RED: begin
                // negative red sector wraps round the full turn; minus zero stays zero
                if (in_data.neg && qx != '0) hue_next = rhc_pkg::HUE_TURN - qx;
                else                         hue_next = qx;
            end
            rhc_pkg::BR_GREEN: begin
                hue_next = in_data.neg ? rhc_pkg::HUE_GREEN_BASE - qx
                                       : rhc_pkg::HUE_GREEN_BASE + qx;
            end
            rhc_pkg::BR_BLUE: begin
                hue_next = in_data.neg ? rhc_pkg::HUE_BLUE_BASE - qx
                                       : rhc_pkg::HUE_BLUE_BASE + qx;
            end
            default: hue_next = '0;
        endcase
        if (in_data.gray) hue_next = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            hue_reg    <= hue_next;
            sat_reg    <= in_data.gray ? '0 : in_data.q_sat[rhc_pkg::PixW-1:0];
            bright_reg <= in_data.bright;
        end
    end

endmodule
